// ----- hw/rtl/handle_heap_refcount_gc_top_assert.svh -----
// Assertion macros for the handle heap block.
// Used by the checker module; no other dependencies.
`ifndef HANDLE_HEAP_REFCOUNT_GC_TOP_ASSERT_SVH
`define HANDLE_HEAP_REFCOUNT_GC_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define HH_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define HH_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hw/rtl/hhrc_pkg.sv -----
// Shared types and constants of the handle heap block.
// No dependencies.
package hhrc_pkg;
    localparam int Slots = 64;
    localparam int TempDepth = 128;
    localparam int CountBits = 16;
    localparam int SlotW = $clog2(Slots);
    localparam int TempW = $clog2(TempDepth);

    typedef logic [SlotW-1:0] slot_t;
    typedef logic [CountBits-1:0] count_t;

    typedef enum logic [3:0] {
        CMD_ALLOC_OBJ = 4'd0,
        CMD_ALLOC_LIST = 4'd1,
        CMD_REF = 4'd2,
        CMD_UNREF = 4'd3,
        CMD_CLEAR_TEMP = 4'd4,
        CMD_SHADE = 4'd5,
        CMD_POP_GRAY = 4'd6,
        CMD_SWEEP = 4'd7,
        CMD_CLEAR_ALL = 4'd8
    } cmd_t;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_NOT_LIVE = 3'd2;
    localparam logic [2:0] ST_COUNT = 3'd3;
    localparam logic [2:0] ST_TEMP_FULL = 3'd4;
    localparam logic [2:0] ST_GRAY = 3'd5;

    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_GRAY = 2'd1;
    localparam logic [1:0] COLOR_BLACK = 2'd2;

    // Slot record: live, list, persistent, color, count
    typedef struct packed {
        logic live;
        logic lst;
        logic pers;
        logic [1:0] color;
        count_t cnt;
    } rec_t;
    localparam int RecW = $bits(rec_t);
endpackage

// ----- hw/rtl/hhrc_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module hhrc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/handle_heap_refcount_gc_top.sv -----
// Top level of the handle heap: command sequencer around the slot, free,
// temp and gray memories. Depends on hhrc_pkg and hhrc_ram.
//
// Usage: one command item enters on s_cmd/s_slot with s_valid/s_ready and
// produces exactly one result item on m_status, m_slot_out, m_is_list,
// m_freed_count, m_gray_empty with m_valid/m_ready.
// Ref, unref, shade, alloc and pop gray read the slot record in S_RD, write
// it back in S_EXEC and raise m_valid in S_OUT; no new command item is
// taken until the result is accepted. Clear temp walks S_TRD and S_TCHK once
// per logged entry, sweep walks S_SWRD and S_SWCHK once per slot, and clear
// all walks S_INIT once per slot.
// After reset, and after clear all, the block runs a clearing pass over all
// 64 slots of the slot and free memories before s_ready rises.
// One item is worked at a time; the result sits in an output register, and
// while the receiver stalls s_ready stays low, so no state changes.
module handle_heap_refcount_gc_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_cmd,
    input  logic [5:0] s_slot,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [5:0] m_slot_out,
    output logic       m_is_list,
    output logic [6:0] m_freed_count,
    output logic       m_gray_empty
);
    localparam int SW = hhrc_pkg::SlotW;
    localparam int TW = hhrc_pkg::TempW;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_EXEC, S_TRD, S_TCHK, S_SWRD, S_SWCHK, S_OUT
    } state_t;

    state_t state_reg;
    logic [3:0] cmd_reg;
    logic [SW-1:0] slot_reg, tgt_reg, idx_reg;
    logic [TW:0] tidx_reg;
    logic [SW:0] free_top_reg, gray_cnt_reg;
    logic [TW:0] temp_cnt_reg;
    logic [6:0] freed_reg;
    logic [2:0] status_reg;
    logic [5:0] sout_reg;
    logic lst_reg;

    // memory ports
    logic rec_we, fs_we, tl_we, gs_we;
    logic [SW-1:0] rec_wa, rec_ra, fs_wa, fs_ra, gs_wa, gs_ra;
    logic [TW-1:0] tl_wa, tl_ra;
    hhrc_pkg::rec_t rec_wd, rec_rd;
    logic [SW-1:0] fs_wd, fs_rd, tl_wd, tl_rd, gs_wd, gs_rd;

    hhrc_ram #(.Width(hhrc_pkg::RecW), .Depth(hhrc_pkg::Slots)) u_rec (
        .aclk(aclk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
        .raddr(rec_ra), .rdata(rec_rd));
    hhrc_ram #(.Width(SW), .Depth(hhrc_pkg::Slots)) u_free (
        .aclk(aclk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
        .raddr(fs_ra), .rdata(fs_rd));
    hhrc_ram #(.Width(SW), .Depth(hhrc_pkg::TempDepth)) u_temp (
        .aclk(aclk), .we(tl_we), .waddr(tl_wa), .wdata(tl_wd),
        .raddr(tl_ra), .rdata(tl_rd));
    hhrc_ram #(.Width(SW), .Depth(hhrc_pkg::Slots)) u_gray (
        .aclk(aclk), .we(gs_we), .waddr(gs_wa), .wdata(gs_wd),
        .raddr(gs_ra), .rdata(gs_rd));

    localparam logic [SW:0] SlotsV = SW'(0) + (SW+1)'(hhrc_pkg::Slots);
    localparam logic [TW:0] TempV = (TW+1)'(hhrc_pkg::TempDepth);
    localparam hhrc_pkg::count_t CntMax = '1;

    logic alloc_c, fs_empty, tl_full, gs_full;
    assign alloc_c = (cmd_reg == hhrc_pkg::CMD_ALLOC_OBJ) ||
                     (cmd_reg == hhrc_pkg::CMD_ALLOC_LIST);
    assign fs_empty = (free_top_reg == '0);
    assign tl_full = (temp_cnt_reg >= TempV);
    assign gs_full = (gray_cnt_reg >= SlotsV);

    logic [SW:0] ft_m1, gc_m1;
    assign ft_m1 = free_top_reg - 1'b1;
    assign gc_m1 = gray_cnt_reg - 1'b1;

    // Read address selection and write back for init, exec, clear temp and sweep
    always_comb begin
        rec_we = 1'b0; rec_wa = tgt_reg; rec_wd = rec_rd; rec_ra = tgt_reg;
        fs_we = 1'b0; fs_wa = free_top_reg[SW-1:0]; fs_wd = idx_reg;
        fs_ra = ft_m1[SW-1:0];
        tl_we = 1'b0; tl_wa = temp_cnt_reg[TW-1:0]; tl_wd = tgt_reg;
        tl_ra = tidx_reg[TW-1:0];
        gs_we = 1'b0; gs_wa = gray_cnt_reg[SW-1:0]; gs_wd = slot_reg;
        gs_ra = gc_m1[SW-1:0];
        unique case (state_reg)
            S_INIT: begin
                rec_we = 1'b1; rec_wa = idx_reg; rec_wd = '0;
                fs_we = 1'b1; fs_wa = idx_reg; fs_wd = idx_reg;
            end
            // first log entry is read ahead of the walk
            S_IDLE: tl_ra = '0;
            // pop gray reads the record of the slot on top of the gray stack
            S_RD: rec_ra = (cmd_reg == hhrc_pkg::CMD_POP_GRAY) ? gs_rd : slot_reg;
            S_EXEC: begin
                rec_ra = tgt_reg;
                if (alloc_c) begin
                    rec_we = !fs_empty && !tl_full; rec_wa = fs_rd;
                    rec_wd = '{live: 1'b1, lst: cmd_reg[0], pers: 1'b0,
                               color: hhrc_pkg::COLOR_WHITE, cnt: '0};
                    tl_we = rec_we; tl_wd = fs_rd;
                end else if (cmd_reg == hhrc_pkg::CMD_REF) begin
                    rec_we = rec_rd.live; rec_wd.pers = 1'b1;
                    if (rec_rd.cnt != CntMax) rec_wd.cnt = rec_rd.cnt + 1'b1;
                end else if (cmd_reg == hhrc_pkg::CMD_UNREF) begin
                    rec_we = rec_rd.live && (rec_rd.cnt != '0);
                    rec_wd.cnt = rec_rd.cnt - 1'b1;
                    tl_we = rec_we && (rec_rd.cnt == hhrc_pkg::count_t'(1)) && !tl_full;
                end else if (cmd_reg == hhrc_pkg::CMD_SHADE) begin
                    rec_we = rec_rd.live && (rec_rd.color != hhrc_pkg::COLOR_GRAY)
                             && !gs_full;
                    rec_wd.color = hhrc_pkg::COLOR_GRAY;
                    gs_we = rec_we;
                end else if (cmd_reg == hhrc_pkg::CMD_POP_GRAY) begin
                    rec_we = rec_rd.live && (gray_cnt_reg != '0);
                    rec_wd.color = hhrc_pkg::COLOR_BLACK;
                end
            end
            S_TCHK: begin
                rec_wa = tl_rd;
                rec_we = rec_rd.live && ((rec_rd.cnt == '0) || !rec_rd.pers);
                rec_wd.live = 1'b0;
                fs_we = rec_we && (free_top_reg < SlotsV);
                fs_wd = tl_rd;
                tl_ra = TW'(tidx_reg + 1'b1);
            end
            S_TRD: rec_ra = tl_rd;
            S_SWRD: rec_ra = idx_reg;
            S_SWCHK: begin
                rec_wa = idx_reg;
                rec_we = rec_rd.live && (rec_rd.color == hhrc_pkg::COLOR_WHITE);
                rec_wd.live = 1'b0;
                fs_we = rec_we && (free_top_reg < SlotsV);
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            cmd_reg <= '0;
            idx_reg <= '0;
            free_top_reg <= SlotsV;
            temp_cnt_reg <= '0;
            gray_cnt_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            unique case (state_reg)
                S_INIT: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == SW'(hhrc_pkg::Slots - 1)) begin
                        if (cmd_reg == hhrc_pkg::CMD_CLEAR_ALL) begin
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg <= s_cmd; slot_reg <= s_slot; tgt_reg <= s_slot;
                        status_reg <= hhrc_pkg::ST_OK; sout_reg <= '0;
                        lst_reg <= 1'b0; freed_reg <= '0;
                        idx_reg <= '0; tidx_reg <= '0;
                        unique case (s_cmd)
                            hhrc_pkg::CMD_ALLOC_OBJ, hhrc_pkg::CMD_ALLOC_LIST,
                            hhrc_pkg::CMD_REF, hhrc_pkg::CMD_UNREF,
                            hhrc_pkg::CMD_SHADE, hhrc_pkg::CMD_POP_GRAY:
                                state_reg <= S_RD;
                            hhrc_pkg::CMD_CLEAR_TEMP: state_reg <= S_TRD;
                            hhrc_pkg::CMD_SWEEP: state_reg <= S_SWRD;
                            hhrc_pkg::CMD_CLEAR_ALL: begin
                                free_top_reg <= SlotsV; temp_cnt_reg <= '0;
                                gray_cnt_reg <= '0;
                                state_reg <= S_INIT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_RD: begin
                    if (cmd_reg == hhrc_pkg::CMD_POP_GRAY) tgt_reg <= gs_rd;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_OUT;
                    if (alloc_c) begin
                        if (fs_empty) status_reg <= hhrc_pkg::ST_FULL;
                        else if (tl_full) status_reg <= hhrc_pkg::ST_TEMP_FULL;
                        else begin
                            free_top_reg <= ft_m1;
                            temp_cnt_reg <= temp_cnt_reg + 1'b1;
                            sout_reg <= fs_rd; lst_reg <= cmd_reg[0];
                        end
                    end else if (cmd_reg == hhrc_pkg::CMD_REF) begin
                        if (!rec_rd.live) status_reg <= hhrc_pkg::ST_NOT_LIVE;
                        else if (rec_rd.cnt == CntMax) status_reg <= hhrc_pkg::ST_COUNT;
                    end else if (cmd_reg == hhrc_pkg::CMD_UNREF) begin
                        if (rec_rd.live) begin
                            if (rec_rd.cnt == '0) status_reg <= hhrc_pkg::ST_COUNT;
                            else if (rec_rd.cnt == hhrc_pkg::count_t'(1)) begin
                                if (tl_full) status_reg <= hhrc_pkg::ST_TEMP_FULL;
                                else temp_cnt_reg <= temp_cnt_reg + 1'b1;
                            end
                        end
                    end else if (cmd_reg == hhrc_pkg::CMD_SHADE) begin
                        if (!rec_rd.live) status_reg <= hhrc_pkg::ST_NOT_LIVE;
                        else if (rec_rd.color == hhrc_pkg::COLOR_GRAY || gs_full)
                            status_reg <= hhrc_pkg::ST_GRAY;
                        else gray_cnt_reg <= gray_cnt_reg + 1'b1;
                    end else begin
                        if (gray_cnt_reg == '0) status_reg <= hhrc_pkg::ST_GRAY;
                        else begin
                            gray_cnt_reg <= gc_m1;
                            sout_reg <= tgt_reg; lst_reg <= rec_rd.lst;
                            if (!rec_rd.live) status_reg <= hhrc_pkg::ST_NOT_LIVE;
                        end
                    end
                end
                // clear temp walk: read log entry, then slot record
                S_TRD: begin
                    if (tidx_reg >= temp_cnt_reg) begin
                        temp_cnt_reg <= '0; state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_TCHK;
                    end
                end
                S_TCHK: begin
                    if (rec_we) begin
                        freed_reg <= freed_reg + 1'b1;
                        if (fs_we) free_top_reg <= free_top_reg + 1'b1;
                    end
                    tidx_reg <= tidx_reg + 1'b1;
                    state_reg <= S_TRD;
                end
                S_SWRD: begin
                    if (gray_cnt_reg != '0) begin
                        status_reg <= hhrc_pkg::ST_GRAY; state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_SWCHK;
                    end
                end
                S_SWCHK: begin
                    if (rec_we) begin
                        freed_reg <= freed_reg + 1'b1;
                        if (fs_we) free_top_reg <= free_top_reg + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == SW'(hhrc_pkg::Slots - 1)) state_reg <= S_OUT;
                    else state_reg <= S_SWRD;
                end
                S_OUT: begin
                    m_valid <= 1'b1;
                    if (m_valid && m_ready) begin
                        m_valid <= 1'b0; state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // S_TRD needs the temp read addressed in the cycle before; tl_ra tracks tidx.
    // Note: on S_TCHK the rec read was issued in S_TRD from tl_rd.

    assign s_ready = (state_reg == S_IDLE);
    assign m_status = status_reg;
    assign m_slot_out = sout_reg;
    assign m_is_list = lst_reg;
    assign m_freed_count = freed_reg;
    assign m_gray_empty = (gray_cnt_reg == '0);
endmodule

// ----- hw/rtl/hhrc_checker.sv -----
// Port-level checker for the handle heap block, bound to the top level.
// Depends on handle_heap_refcount_gc_top_assert.svh.
`include "handle_heap_refcount_gc_top_assert.svh"
module hhrc_port_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic [6:0] m_freed_count
);
    `HH_ASSERT_IMP(a_one_side, aclk, aresetn, m_valid, !s_ready, "ready while result pending")
    `HH_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `HH_ASSERT_IMP(a_status, aclk, aresetn, m_valid, m_status <= 3'd5, "bad status")
    `HH_ASSERT_IMP(a_freed, aclk, aresetn, m_valid, m_freed_count <= 7'd64, "freed overflow")
endmodule

bind handle_heap_refcount_gc_top hhrc_port_checker u_hhrc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_freed_count(m_freed_count));
